### hdl/bfgcm_pkg.sv
package bfgcm_pkg;

  localparam int ROUNDS     = 16;
  localparam int P_WORDS    = ROUNDS + 2;
  localparam int P_IDX_W    = $clog2(P_WORDS);
  localparam int RND_W      = $clog2(ROUNDS);
  localparam int SBOX_DEPTH = 256;
  localparam int SBOX_NUM   = 4;
  localparam int S_WORDS    = SBOX_NUM * SBOX_DEPTH;
  localparam int MUL_BITS   = 4;
  localparam int MUL_CYC    = 64 / MUL_BITS;
  localparam int MUL_CNT_W  = $clog2(MUL_CYC);

  localparam logic [63:0] GF_POLY_LOW = 64'h1b;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  localparam logic [1:0] SRC_ZERO  = 2'd0;
  localparam logic [1:0] SRC_CTR   = 2'd1;
  localparam logic [1:0] SRC_NONCE = 2'd2;

  typedef struct packed {
    logic             cap;
    logic             bf_init;
    logic [1:0]       bf_src;
    logic             bf_a;
    logic             bf_b;
    logic             bf_end;
    logic [RND_W-1:0] round;
    logic             mul_init;
    logic             mul_step;
    logic             commit;
    logic             out_load;
  } cmd_t;

endpackage

### hdl/bfgcm_if.sv
interface bfgcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] key_index;
  logic [31:0] key_word;
  logic [63:0] nonce;
  logic [63:0] data_in;
  logic [3:0]  valid_bytes;
  logic [63:0] expected_tag;

  modport source (output valid, kind, key_index, key_word, nonce, data_in, valid_bytes,
                  expected_tag, input ready);
  modport sink (input valid, kind, key_index, key_word, nonce, data_in, valid_bytes,
                expected_tag, output ready);
endinterface

interface bfgcm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;
  logic [3:0]  out_bytes;
  logic [63:0] tag;
  logic        is_tag;
  logic        auth_ok;

  modport source (output valid, data_out, out_bytes, tag, is_tag, auth_ok, input ready);
  modport sink (input valid, data_out, out_bytes, tag, is_tag, auth_ok, output ready);
endinterface

### hdl/bfgcm_ram.sv
module bfgcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bfgcm_ctrl.sv
module bfgcm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [3:0]        in_valid_bytes,
  output logic              out_valid,
  input  logic              out_ready,
  output bfgcm_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BFA    = 3'd1;
  localparam logic [2:0] S_BFB    = 3'd2;
  localparam logic [2:0] S_BFEND  = 3'd3;
  localparam logic [2:0] S_MULI   = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0]                          state_r, state_nxt;
  logic [1:0]                          kind_r, kind_nxt;
  logic [bfgcm_pkg::RND_W-1:0]         rnd_r, rnd_nxt;
  logic [bfgcm_pkg::MUL_CNT_W-1:0]     mcnt_r, mcnt_nxt;
  logic                                ov_r, ov_nxt;
  logic                                acc;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    rnd_nxt   = rnd_r;
    mcnt_nxt  = mcnt_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.round = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.cap  = 1'b1;
          kind_nxt = in_kind;
          rnd_nxt  = '0;
          case (in_kind)
            bfgcm_pkg::KIND_START: begin
              cmd.bf_init = 1'b1;
              cmd.bf_src  = bfgcm_pkg::SRC_ZERO;
              state_nxt   = S_BFA;
            end
            bfgcm_pkg::KIND_DATA: begin
              if (in_valid_bytes != 4'd0) begin
                cmd.bf_init = 1'b1;
                cmd.bf_src  = bfgcm_pkg::SRC_CTR;
                state_nxt   = S_BFA;
              end
            end
            bfgcm_pkg::KIND_FINISH: begin
              cmd.bf_init = 1'b1;
              cmd.bf_src  = bfgcm_pkg::SRC_NONCE;
              state_nxt   = S_BFA;
            end
            default: ;
          endcase
        end
      end
      S_BFA: begin
        cmd.bf_a  = 1'b1;
        state_nxt = S_BFB;
      end
      S_BFB: begin
        cmd.bf_b = 1'b1;
        if (rnd_r == bfgcm_pkg::RND_W'(bfgcm_pkg::ROUNDS - 1)) begin
          state_nxt = S_BFEND;
        end else begin
          rnd_nxt   = rnd_r + 1'b1;
          state_nxt = S_BFA;
        end
      end
      S_BFEND: begin
        cmd.bf_end = 1'b1;
        state_nxt  = (kind_r == bfgcm_pkg::KIND_START) ? S_COMMIT : S_MULI;
      end
      S_MULI: begin
        cmd.mul_init = 1'b1;
        mcnt_nxt     = '0;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (mcnt_r == bfgcm_pkg::MUL_CNT_W'(bfgcm_pkg::MUL_CYC - 1)) begin
          state_nxt = S_COMMIT;
        end else begin
          mcnt_nxt = mcnt_r + 1'b1;
        end
      end
      S_COMMIT: begin
        if (kind_r == bfgcm_pkg::KIND_START) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end else if (!ov_r || out_ready) begin
          // The result register is free or drains in this cycle.
          cmd.commit   = 1'b1;
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= bfgcm_pkg::KIND_LOAD;
      rnd_r   <= '0;
      mcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      rnd_r   <= rnd_nxt;
      mcnt_r  <= mcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

### hdl/bfgcm_dp.sv
module bfgcm_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  bfgcm_pkg::cmd_t  cmd,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic [1:0]       in_kind,
  input  logic [10:0]      in_key_index,
  input  logic [31:0]      in_key_word,
  input  logic [63:0]      in_nonce,
  input  logic [63:0]      in_data_in,
  input  logic [3:0]       in_valid_bytes,
  input  logic [63:0]      in_expected_tag,
  output logic [63:0]      out_data_out,
  output logic [3:0]       out_out_bytes,
  output logic [63:0]      out_tag,
  output logic             out_is_tag,
  output logic             out_auth_ok
);

  logic [31:0] p_r [bfgcm_pkg::P_WORDS];
  logic [63:0] hkey_r, tagacc_r, nonce_r, ctr_r, total_r;
  logic        dec_r;
  logic [1:0]  kind_r;
  logic [63:0] data_r, exp_r;
  logic [3:0]  n_r;
  logic [31:0] l_r, r_r;
  logic [63:0] ks_r;
  logic [63:0] acc_r, mb_r;

  logic [63:0] out_data_r, out_tag_r;
  logic [3:0]  out_bytes_r;
  logic        out_is_tag_r, out_auth_r;

  logic [10:0] sidx;
  logic        s_wr;
  logic [31:0] xl, fval;
  logic [63:0] src, padmask, text, res, fold, acc_step, fin_tag;
  logic [3:0]  n_in;
  logic [31:0] s_rd [bfgcm_pkg::SBOX_NUM];
  logic [7:0]  s_ra [bfgcm_pkg::SBOX_NUM];

  assign sidx = in_key_index - 11'(bfgcm_pkg::P_WORDS);
  assign s_wr = cmd.cap && (in_kind == bfgcm_pkg::KIND_LOAD) &&
                (in_key_index >= 11'(bfgcm_pkg::P_WORDS)) &&
                (sidx < 11'(bfgcm_pkg::S_WORDS));
  assign n_in = (in_valid_bytes > 4'd8) ? 4'd8 : in_valid_bytes;

  assign xl = l_r ^ p_r[{1'b0, cmd.round}];
  assign s_ra[0] = xl[31:24];
  assign s_ra[1] = xl[23:16];
  assign s_ra[2] = xl[15:8];
  assign s_ra[3] = xl[7:0];
  assign fval = ((s_rd[0] + s_rd[1]) ^ s_rd[2]) + s_rd[3];

  for (genvar k = 0; k < bfgcm_pkg::SBOX_NUM; k++) begin : g_sbox
    bfgcm_ram #(.WIDTH(32), .DEPTH(bfgcm_pkg::SBOX_DEPTH)) u_ram (
      .clk   (clk),
      .we    (s_wr && (sidx[9:8] == 2'(k))),
      .waddr (sidx[7:0]),
      .wdata (in_key_word),
      .raddr (s_ra[k]),
      .rdata (s_rd[k])
    );
  end

  always_comb begin
    case (cmd.bf_src)
      bfgcm_pkg::SRC_CTR:   src = ctr_r ^ nonce_r;
      bfgcm_pkg::SRC_NONCE: src = nonce_r;
      default:              src = '0;
    endcase
  end

  // Padding bytes sit below the valid leading bytes.
  assign padmask = 64'hffff_ffff_ffff_ffff >> {n_r, 3'b000};
  assign text    = data_r & ~padmask;
  assign res     = ks_r ^ text;
  assign fold    = dec_r ? (text | (ks_r & padmask)) : res;
  assign fin_tag = acc_r ^ ks_r;

  always_comb begin
    acc_step = acc_r;
    for (int i = 0; i < bfgcm_pkg::MUL_BITS; i++) begin
      acc_step = {acc_step[62:0], 1'b0} ^ (acc_step[63] ? bfgcm_pkg::GF_POLY_LOW : 64'd0);
      if (mb_r[63 - i]) begin
        acc_step = acc_step ^ hkey_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r <= in_kind;
      data_r <= in_data_in;
      exp_r  <= in_expected_tag;
      n_r    <= n_in;
      if (in_kind == bfgcm_pkg::KIND_LOAD &&
          in_key_index < 11'(bfgcm_pkg::P_WORDS)) begin
        p_r[in_key_index[bfgcm_pkg::P_IDX_W-1:0]] <= in_key_word;
      end
    end
    if (cmd.bf_init) begin
      l_r <= src[63:32];
      r_r <= src[31:0];
    end
    if (cmd.bf_a) begin
      l_r <= xl;
    end
    if (cmd.bf_b) begin
      l_r <= r_r ^ fval;
      r_r <= l_r;
    end
    if (cmd.bf_end) begin
      ks_r <= {r_r ^ p_r[bfgcm_pkg::ROUNDS + 1], l_r ^ p_r[bfgcm_pkg::ROUNDS]};
    end
    if (cmd.mul_init) begin
      acc_r <= '0;
      mb_r  <= (kind_r == bfgcm_pkg::KIND_DATA) ? (tagacc_r ^ fold) : (tagacc_r ^ total_r);
    end
    if (cmd.mul_step) begin
      acc_r <= acc_step;
      mb_r  <= {mb_r[63-bfgcm_pkg::MUL_BITS:0], {bfgcm_pkg::MUL_BITS{1'b0}}};
    end
    if (cmd.out_load) begin
      if (kind_r == bfgcm_pkg::KIND_DATA) begin
        out_data_r   <= res;
        out_bytes_r  <= n_r;
        out_tag_r    <= '0;
        out_is_tag_r <= 1'b0;
        out_auth_r   <= 1'b1;
      end else begin
        out_data_r   <= '0;
        out_bytes_r  <= 4'd8;
        out_tag_r    <= fin_tag;
        out_is_tag_r <= 1'b1;
        out_auth_r   <= dec_r ? (fin_tag == exp_r) : 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hkey_r   <= '0;
      tagacc_r <= '0;
      nonce_r  <= '0;
      ctr_r    <= '0;
      total_r  <= '0;
      dec_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        dec_r <= cfg_wdata;
      end
      if (cmd.cap && in_kind == bfgcm_pkg::KIND_START) begin
        nonce_r <= in_nonce;
      end
      if (cmd.commit) begin
        case (kind_r)
          bfgcm_pkg::KIND_START: begin
            hkey_r   <= ks_r;
            ctr_r    <= 64'd1;
            tagacc_r <= '0;
            total_r  <= '0;
          end
          bfgcm_pkg::KIND_DATA: begin
            tagacc_r <= acc_r;
            ctr_r    <= ctr_r + 64'd1;
            total_r  <= total_r + 64'(n_r);
          end
          bfgcm_pkg::KIND_FINISH: begin
            hkey_r   <= '0;
            tagacc_r <= '0;
            nonce_r  <= '0;
            ctr_r    <= '0;
            total_r  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_data_out  = out_data_r;
  assign out_out_bytes = out_bytes_r;
  assign out_tag       = out_tag_r;
  assign out_is_tag    = out_is_tag_r;
  assign out_auth_ok   = out_auth_r;

endmodule

### hdl/blowfish_ctr_gf64_auth.sv
// Channel   Direction  Transfer when         Payload
// in_ch     input      in_ch.valid & ready   kind, key_index, key_word, nonce, data_in,
//                                            valid_bytes, expected_tag
// out_ch    output     out_ch.valid & ready  data_out, out_bytes, tag, is_tag, auth_ok
// cfg       input      cfg_we                cfg_wdata (decrypt_mode)
//
// A key load is written when it is taken; a start runs 16 Blowfish rounds, each one stepping
// through S_BFA and S_BFB around the registered S-box RAM reads. A data block with valid
// bytes or a finish runs the rounds and then the GF(2^64) multiply at 4 bits per cycle.
// Reset is synchronous on rst_n and clears the message state; the key store is not cleared.
// A finished result waits in the output register; the next item may be taken meanwhile
// and stalls only at its own commit until the register is free.
module blowfish_ctr_gf64_auth (
  input  logic         clk,
  input  logic         rst_n,
  bfgcm_in_if.sink     in_ch,
  bfgcm_out_if.source  out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  bfgcm_pkg::cmd_t cmd;

  bfgcm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_kind        (in_ch.kind),
    .in_valid_bytes (in_ch.valid_bytes),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .cmd            (cmd)
  );

  bfgcm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_ch.kind),
    .in_key_index    (in_ch.key_index),
    .in_key_word     (in_ch.key_word),
    .in_nonce        (in_ch.nonce),
    .in_data_in      (in_ch.data_in),
    .in_valid_bytes  (in_ch.valid_bytes),
    .in_expected_tag (in_ch.expected_tag),
    .out_data_out    (out_ch.data_out),
    .out_out_bytes   (out_ch.out_bytes),
    .out_tag         (out_ch.tag),
    .out_is_tag      (out_ch.is_tag),
    .out_auth_ok     (out_ch.auth_ok)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register loaded while a result is still pending");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.out_load))
    else $error("result appeared without a commit");

  a_data_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_tag) |-> (out_ch.tag == 64'd0 && out_ch.auth_ok))
    else $error("data result carries tag fields");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_step || cmd.bf_a || cmd.bf_b) |-> !in_ch.ready)
    else $error("input accepted while a block is in progress");

endmodule

### verif/tb_blowfish_ctr_gf64_auth.sv
`timescale 1ns / 100ps

module tb_blowfish_ctr_gf64_auth;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;
  localparam int N_RANDOM = 800;

  typedef struct packed {
    logic [63:0] data_out;
    logic [3:0]  out_bytes;
    logic [63:0] tag;
    logic        is_tag;
    logic        auth_ok;
  } result_t;

  typedef struct {
    logic [1:0]  kind;
    logic [10:0] key_index;
    logic [31:0] key_word;
    logic [63:0] nonce;
    logic [63:0] data_in;
    logic [3:0]  valid_bytes;
    logic [63:0] expected_tag;
    logic        has_fixed;
    result_t     fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  bfgcm_in_if  in_ch ();
  bfgcm_out_if out_ch ();

  blowfish_ctr_gf64_auth u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow state of the cipher and the authenticator.
  logic [31:0] mdl_p [bfgcm_pkg::P_WORDS];
  logic [31:0] mdl_s [bfgcm_pkg::S_WORDS];
  logic [63:0] mdl_h, mdl_acc, mdl_nonce, mdl_ctr, mdl_len;
  logic        mdl_decrypt;

  result_t pending_results[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  n_sent = 0;
  int  n_data = 0;
  int  n_tags = 0;

  function automatic logic [31:0] bf_feistel(logic [31:0] x);
    logic [31:0] a, b, c, d;
    a = mdl_s[x[31:24]];
    b = mdl_s[256 + x[23:16]];
    c = mdl_s[512 + x[15:8]];
    d = mdl_s[768 + x[7:0]];
    return ((a + b) ^ c) + d;
  endfunction

  function automatic logic [63:0] bf_encrypt(logic [63:0] v);
    logic [31:0] l, r, t;
    l = v[63:32];
    r = v[31:0];
    for (int i = 0; i < bfgcm_pkg::ROUNDS; i++) begin
      l = l ^ mdl_p[i];
      r = r ^ bf_feistel(l);
      t = l; l = r; r = t;
    end
    t = l; l = r; r = t;
    r = r ^ mdl_p[bfgcm_pkg::ROUNDS];
    l = l ^ mdl_p[bfgcm_pkg::ROUNDS + 1];
    return {l, r};
  endfunction

  function automatic logic [63:0] gf64_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = {acc[62:0], 1'b0} ^ (acc[63] ? bfgcm_pkg::GF_POLY_LOW : 64'h0);
      if (b[i]) acc = acc ^ a;
    end
    return acc;
  endfunction

  // Advances the shadow state by one accepted item and queues its result, if any.
  task automatic predict_auth(input stim_row_t it);
    logic [63:0] ks, text, pad, fold, t;
    int n;
    result_t r;
    case (it.kind)
      bfgcm_pkg::KIND_LOAD: begin
        if (it.key_index < bfgcm_pkg::P_WORDS) mdl_p[it.key_index] = it.key_word;
        else if (it.key_index < bfgcm_pkg::P_WORDS + bfgcm_pkg::S_WORDS)
          mdl_s[it.key_index - bfgcm_pkg::P_WORDS] = it.key_word;
      end
      bfgcm_pkg::KIND_START: begin
        mdl_nonce = it.nonce;
        mdl_h = bf_encrypt(64'h0);
        mdl_ctr = 64'd1;
        mdl_acc = '0;
        mdl_len = '0;
      end
      bfgcm_pkg::KIND_DATA: begin
        n = it.valid_bytes;
        if (n != 0) begin
          if (n > 8) n = 8;
          pad = (n == 8) ? 64'h0 : ((64'h1 << ((8 - n) * 8)) - 64'h1);
          ks = bf_encrypt(mdl_ctr ^ mdl_nonce);
          mdl_ctr = mdl_ctr + 64'd1;
          text = it.data_in & ~pad;
          fold = mdl_decrypt ? (text | (ks & pad)) : (ks ^ text);
          mdl_acc = gf64_mul(mdl_acc ^ fold, mdl_h);
          mdl_len = mdl_len + 64'(n);
          r.data_out = ks ^ text;
          r.out_bytes = 4'(n);
          r.tag = '0;
          r.is_tag = 1'b0;
          r.auth_ok = 1'b1;
          if (it.has_fixed) r = it.fixed;
          pending_results.push_back(r);
        end
      end
      default: begin
        t = gf64_mul(mdl_acc ^ mdl_len, mdl_h) ^ bf_encrypt(mdl_nonce);
        r.data_out = '0;
        r.out_bytes = 4'd8;
        r.tag = t;
        r.is_tag = 1'b1;
        r.auth_ok = mdl_decrypt ? (t == it.expected_tag) : 1'b1;
        if (it.has_fixed) r = it.fixed;
        pending_results.push_back(r);
        mdl_h = '0; mdl_acc = '0; mdl_nonce = '0; mdl_ctr = '0; mdl_len = '0;
      end
    endcase
  endtask

  task automatic send_item(input stim_row_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= it.kind;
    in_ch.key_index    <= it.key_index;
    in_ch.key_word     <= it.key_word;
    in_ch.nonce        <= it.nonce;
    in_ch.data_in      <= it.data_in;
    in_ch.valid_bytes  <= it.valid_bytes;
    in_ch.expected_tag <= it.expected_tag;
    do @(posedge clk); while (!in_ch.ready);
    predict_auth(it);
    n_sent++;
  endtask

  function automatic stim_row_t make_row(logic [1:0] kind);
    stim_row_t it;
    it.kind = kind;
    it.key_index = 11'($urandom_range(bfgcm_pkg::P_WORDS + bfgcm_pkg::S_WORDS - 1));
    it.key_word = $urandom;
    it.nonce = {$urandom, $urandom};
    it.data_in = {$urandom, $urandom};
    it.valid_bytes = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
    it.expected_tag = {$urandom, $urandom};
    it.has_fixed = 1'b0;
    it.fixed = '0;
    return it;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    in_ch.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_decrypt = mode;
  endtask

  task automatic load_key();
    stim_row_t it;
    for (int i = 0; i < bfgcm_pkg::P_WORDS + bfgcm_pkg::S_WORDS; i++) begin
      it = make_row(bfgcm_pkg::KIND_LOAD);
      it.key_index = 11'(i);
      it.key_word = (i == 0) ? 32'hffff_ffff : (i == 1) ? 32'h0 : $urandom;
      send_item(it);
    end
  endtask

  // Mostly well-formed messages with random content; the rest is stray items.
  task automatic random_phase(input int items);
    stim_row_t it;
    int nblk;
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        it = make_row(2'($urandom_range(3)));
        if (it.kind == bfgcm_pkg::KIND_LOAD && $urandom_range(1))
          it.key_index = 11'($urandom_range(2047));
        send_item(it);
        sent++;
      end else begin
        send_item(make_row(bfgcm_pkg::KIND_START));
        nblk = $urandom_range(6);
        for (int b = 0; b < nblk; b++) begin
          it = make_row(bfgcm_pkg::KIND_DATA);
          if (b != nblk - 1 && $urandom_range(7) != 0) it.valid_bytes = 4'd8;
          send_item(it);
        end
        send_item(make_row(bfgcm_pkg::KIND_FINISH));
        sent += nblk + 2;
      end
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= rst_n && !($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.data_out, out_ch.out_bytes, out_ch.tag, out_ch.is_tag, out_ch.auth_ok};
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: data_out %h tag %h", got.data_out, got.tag);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.data_out !== exp_r.data_out) begin
          $error("data_out expected %h actual %h", exp_r.data_out, got.data_out);
          errors++;
        end
        if (got.out_bytes !== exp_r.out_bytes) begin
          $error("out_bytes expected %0d actual %0d", exp_r.out_bytes, got.out_bytes);
          errors++;
        end
        if (got.tag !== exp_r.tag) begin
          $error("tag expected %h actual %h", exp_r.tag, got.tag);
          errors++;
        end
        if (got.is_tag !== exp_r.is_tag) begin
          $error("is_tag expected %b actual %b", exp_r.is_tag, got.is_tag);
          errors++;
        end
        if (got.auth_ok !== exp_r.auth_ok) begin
          $error("auth_ok expected %b actual %b", exp_r.auth_ok, got.auth_ok);
          errors++;
        end
        if (got.is_tag) n_tags++;
        else n_data++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
      $display("tb_blowfish_ctr_gf64_auth failed");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    stim_row_t it;
    int k;

    in_ch.valid = 1'b0;
    in_ch.kind = bfgcm_pkg::KIND_LOAD;
    in_ch.key_index = '0;
    in_ch.key_word = '0;
    in_ch.nonce = '0;
    in_ch.data_in = '0;
    in_ch.valid_bytes = '0;
    in_ch.expected_tag = '0;
    out_ch.ready = 1'b0;
    mdl_h = '0; mdl_acc = '0; mdl_nonce = '0; mdl_ctr = '0; mdl_len = '0;
    mdl_decrypt = 1'b0;
    foreach (mdl_p[i]) mdl_p[i] = '0;
    foreach (mdl_s[i]) mdl_s[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The whole key goes in before any item reads the S-boxes.
    load_key();
    write_mode(1'b0);

    // Finish straight away: every message word is zero, so the tag is the
    // cipher of zero only, which the predictor still computes.
    it = make_row(bfgcm_pkg::KIND_FINISH);
    dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_START); it.nonce = '1; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_DATA); it.data_in = '1; it.valid_bytes = 4'd8;
    dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_DATA); it.data_in = '0; it.valid_bytes = 4'd1;
    dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_DATA); it.valid_bytes = 4'd7; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_DATA); it.valid_bytes = 4'd15; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_DATA); it.valid_bytes = 4'd0; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_LOAD); it.key_index = 11'd2047; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_LOAD); it.key_index = 11'd1042; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_FINISH); dir_rows.push_back(it);
    // Data after finish uses zero hash key and zero counter and nonce.
    it = make_row(bfgcm_pkg::KIND_DATA); dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_FINISH); dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_START); it.nonce = '0; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_DATA); it.valid_bytes = 4'd3; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_DATA); it.valid_bytes = 4'd8; dir_rows.push_back(it);
    it = make_row(bfgcm_pkg::KIND_FINISH); dir_rows.push_back(it);
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    wait_drained();

    // Decrypt: a wrong tag must be rejected with auth_ok low.
    write_mode(1'b1);
    send_item(make_row(bfgcm_pkg::KIND_START));
    it = make_row(bfgcm_pkg::KIND_DATA); it.valid_bytes = 4'd5; send_item(it);
    it = make_row(bfgcm_pkg::KIND_FINISH);
    send_item(it);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 64; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 64; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (k = 0; k < 2; k++) begin
        write_mode(1'($urandom_range(1)));
        random_phase(N_RANDOM / 8);
        wait_drained();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("covered %0d items, %0d data results and %0d tags, both modes",
             n_sent, n_data, n_tags);
    $display("phases with no idling, sender gaps, receiver stalls and both");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_blowfish_ctr_gf64_auth passed");
    end else begin
      $display("tb_blowfish_ctr_gf64_auth failed");
    end
    $finish;
  end

endmodule
